>>> design/rasr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasr_pkg: shared types and constants for the rational add/sub/reduce unit
// Holds mode codes, widths, the queue depth and the result structure.
// ----------------------------------------------------------------------------
package rasr_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int RES_NUM_W        = 33;
  localparam int RES_DEN_W        = 31;
  localparam int WORK_W           = 64;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SUB    = 2'd1,
    MODE_EQUAL  = 2'd2,
    MODE_REDUCE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0] res_den;
    logic                 equal;
    logic                 error;
  } result_t;

endpackage

>>> design/rasr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasr_in_if / rasr_out_if: valid/ready channels of the unit
// Request channel carries mode and two fractions; result channel one result.
// ----------------------------------------------------------------------------
interface rasr_in_if #(parameter int OPERAND_BITS = rasr_pkg::OPERAND_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic signed [OPERAND_BITS-1:0] num_a;
  logic signed [OPERAND_BITS-1:0] den_a;
  logic signed [OPERAND_BITS-1:0] num_b;
  logic signed [OPERAND_BITS-1:0] den_b;
  modport source (output valid, mode, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, mode, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rasr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rasr_pkg::RES_NUM_W-1:0] res_num;
  logic [rasr_pkg::RES_DEN_W-1:0]      res_den;
  logic                                equal;
  logic                                error;
  modport source (output valid, res_num, res_den, equal, error, input ready);
  modport sink   (input valid, res_num, res_den, equal, error, output ready);
endinterface

>>> design/rasr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasr_front: request intake and classification
// Checks denominators, splits sign and magnitude, and queues a job.
// ----------------------------------------------------------------------------
module rasr_front #(
  parameter int OPERAND_BITS = rasr_pkg::OPERAND_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rasr_in_if.sink              in_ch,
  output logic                 job_valid,
  input  logic                 job_ready,
  output logic [1:0]           job_mode,
  output logic                 job_err,
  output logic                 job_neg_a,
  output logic [OPERAND_BITS:0] job_mag_a,
  output logic [OPERAND_BITS:0] job_den_a,
  output logic                 job_neg_b,
  output logic [OPERAND_BITS:0] job_mag_b,
  output logic [OPERAND_BITS:0] job_den_b
);
  import rasr_pkg::*;

  localparam int MW    = OPERAND_BITS + 1;
  localparam int JOB_W = 2 + 1 + 2 * (1 + 2 * MW);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [JOB_W-1:0] q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             push, pop;
  logic [JOB_W-1:0] job_in, job_out;
  logic             za, zb, err;

  function automatic logic [MW-1:0] mag_of(input logic [OPERAND_BITS-1:0] v);
    logic [MW-1:0] e;
    e = {v[OPERAND_BITS-1], v};
    return v[OPERAND_BITS-1] ? (~e + MW'(1)) : e;
  endfunction

  assign za  = (in_ch.den_a == '0);
  assign zb  = (in_ch.den_b == '0);
  assign err = za || ((in_ch.mode != MODE_REDUCE) && zb);

  assign job_in = {in_ch.mode, err,
                   in_ch.num_a[OPERAND_BITS-1] ^ in_ch.den_a[OPERAND_BITS-1],
                   mag_of(in_ch.num_a), mag_of(in_ch.den_a),
                   in_ch.num_b[OPERAND_BITS-1] ^ in_ch.den_b[OPERAND_BITS-1],
                   mag_of(in_ch.num_b), mag_of(in_ch.den_b)};

  assign in_ch.ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = job_valid && job_ready;
  assign job_valid = (count_r != '0);
  assign job_out = q_mem[rd_ptr_r];
  assign {job_mode, job_err, job_neg_a, job_mag_a, job_den_a,
          job_neg_b, job_mag_b, job_den_b} = job_out;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_full_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == (PTR_W+1)'(QUEUE_DEPTH)) |-> !in_ch.ready) else $error("ready when full");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1) else $error("count slip");

endmodule

>>> design/rasr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasr_divider: shared restoring divider, one quotient bit per cycle
// Produces quotient and remainder of two unsigned values.
// ----------------------------------------------------------------------------
module rasr_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] quo_r, rem_r, dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted   = {rem_r, quo_r[W-1]};
  assign trial     = shifted - {1'b0, dsr_r};
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r)) else $error("done without work");
  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r) else $error("done while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("counter stuck");

endmodule

>>> design/rasr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasr_back: executes a queued job
// Reduces operand(s); add/sub cross-multiplies and reduces the sum; registers it.
// ----------------------------------------------------------------------------
module rasr_back #(
  parameter int OPERAND_BITS = rasr_pkg::OPERAND_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  logic [1:0]            job_mode,
  input  logic                  job_err,
  input  logic                  job_neg_a,
  input  logic [OPERAND_BITS:0] job_mag_a,
  input  logic [OPERAND_BITS:0] job_den_a,
  input  logic                  job_neg_b,
  input  logic [OPERAND_BITS:0] job_mag_b,
  input  logic [OPERAND_BITS:0] job_den_b,
  rasr_out_if.source            out_ch
);
  import rasr_pkg::*;

  localparam int W = WORK_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_GCD    = 12'b000000000010,
    S_GWAIT  = 12'b000000000100,
    S_DIVM   = 12'b000000001000,
    S_DIVMW  = 12'b000000010000,
    S_DIVD   = 12'b000000100000,
    S_DIVDW  = 12'b000001000000,
    S_NEXT   = 12'b000010000000,
    S_MUL1   = 12'b000100000000,
    S_MUL2   = 12'b001000000000,
    S_COMB   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  // which reduction is running: A, B, or the combined result
  typedef enum logic [2:0] {
    P_A = 3'b001,
    P_B = 3'b010,
    P_R = 3'b100
  } phase_t;

  state_t state_r;
  phase_t phase_r;
  logic [1:0] mode_r;
  logic neg_a_r, neg_b_r, neg_c_r;
  logic [W-1:0] ma_r, da_r, mb_r, db_r, mc_r, dc_r;
  logic [W-1:0] ga_r, gb_r;
  logic [W-1:0] t1_r, t2_r, dd_r;
  logic div_start;
  logic [W-1:0] div_n, div_d, div_q, div_rm;
  logic div_done;
  logic [W-1:0] cur_mag, cur_den;
  logic cur_neg;
  logic s2;
  result_t res_r;
  logic    out_valid_r;

  rasr_divider #(.W(W)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q), .remainder(div_rm)
  );

  always_comb begin
    unique case (phase_r)
      P_A:     begin cur_mag = ma_r; cur_den = da_r; cur_neg = neg_a_r; end
      P_B:     begin cur_mag = mb_r; cur_den = db_r; cur_neg = neg_b_r; end
      default: begin cur_mag = mc_r; cur_den = dc_r; cur_neg = neg_c_r; end
    endcase
  end

  assign s2 = (mode_r == MODE_SUB) ? !neg_b_r : neg_b_r;
  assign div_start = (state_r == S_GCD && gb_r != '0) || state_r == S_DIVM
                     || state_r == S_DIVD;
  always_comb begin
    div_n = ga_r;
    div_d = gb_r;
    if (state_r == S_DIVM) begin
      div_n = cur_mag;
      div_d = ga_r;
    end else if (state_r == S_DIVD) begin
      div_n = cur_den;
      div_d = ga_r;
    end
  end

  // a result still waiting on the output holds off the next job
  assign job_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = res_r.res_num;
  assign out_ch.res_den = res_r.res_den;
  assign out_ch.equal   = res_r.equal;
  assign out_ch.error   = res_r.error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_A;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            mode_r  <= job_mode;
            neg_a_r <= job_neg_a;
            neg_b_r <= job_neg_b;
            ma_r <= W'(job_mag_a);
            da_r <= W'(job_den_a);
            mb_r <= W'(job_mag_b);
            db_r <= W'(job_den_b);
            ga_r <= W'(job_mag_a);
            gb_r <= W'(job_den_a);
            phase_r <= P_A;
            res_r <= '{res_num: '0, res_den: '0, equal: 1'b0, error: job_err};
            if (job_err) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_GCD;
            end
          end
        end
        S_GCD: begin
          // Euclid: gb==0 ends with ga as the divisor
          if (gb_r == '0) begin
            if (ga_r == '0) ga_r <= W'(1);
            state_r <= S_DIVM;
          end else begin
            state_r <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (div_done) begin
            ga_r <= gb_r;
            gb_r <= div_rm;
            state_r <= S_GCD;
          end
        end
        S_DIVM:  state_r <= S_DIVMW;
        S_DIVMW: begin
          if (div_done) begin
            unique case (phase_r)
              P_A:     ma_r <= div_q;
              P_B:     mb_r <= div_q;
              default: mc_r <= div_q;
            endcase
            state_r <= S_DIVD;
          end
        end
        S_DIVD:  state_r <= S_DIVDW;
        S_DIVDW: begin
          if (div_done) begin
            unique case (phase_r)
              P_A:     da_r <= div_q;
              P_B:     db_r <= div_q;
              default: dc_r <= div_q;
            endcase
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          unique case (phase_r)
            P_A: begin
              neg_a_r <= neg_a_r && (ma_r != '0);
              if (mode_r == MODE_REDUCE) begin
                res_r.res_num <= RES_NUM_W'(neg_a_r ? (~ma_r + W'(1)) : ma_r);
                res_r.res_den <= RES_DEN_W'(da_r);
                state_r <= S_OUT;
              end else begin
                phase_r <= P_B;
                ga_r <= mb_r;
                gb_r <= db_r;
                state_r <= S_GCD;
              end
            end
            P_B: begin
              neg_b_r <= neg_b_r && (mb_r != '0);
              if (mode_r == MODE_EQUAL) begin
                res_r.equal <= (neg_a_r == (neg_b_r && (mb_r != '0)))
                               && ma_r == mb_r && da_r == db_r;
                state_r <= S_OUT;
              end else begin
                state_r <= S_MUL1;
              end
            end
            default: begin
              res_r.res_num <= RES_NUM_W'((neg_c_r && mc_r != '0) ?
                                          (~mc_r + W'(1)) : mc_r);
              res_r.res_den <= RES_DEN_W'(dc_r);
              state_r <= S_OUT;
            end
          endcase
        end
        S_MUL1: begin
          t1_r <= W'(ma_r[31:0] * db_r[31:0]);
          t2_r <= W'(mb_r[31:0] * da_r[31:0]);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          dd_r <= W'(da_r[31:0] * db_r[31:0]);
          state_r <= S_COMB;
        end
        S_COMB: begin
          if (neg_a_r == s2) begin
            mc_r <= t1_r + t2_r;
            neg_c_r <= neg_a_r;
          end else if (t1_r >= t2_r) begin
            mc_r <= t1_r - t2_r;
            neg_c_r <= neg_a_r;
          end else begin
            mc_r <= t2_r - t1_r;
            neg_c_r <= s2;
          end
          dc_r <= (dd_r == '0) ? W'(1) : dd_r;
          ga_r <= (neg_a_r == s2) ? t1_r + t2_r :
                  (t1_r >= t2_r) ? t1_r - t2_r : t2_r - t1_r;
          gb_r <= (dd_r == '0) ? W'(1) : dd_r;
          phase_r <= P_R;
          state_r <= S_GCD;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(res_r))
    else $error("result dropped");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.error) |-> (res_r.res_num == '0 && !res_r.equal))
    else $error("error result not zero");

endmodule

>>> design/rational_add_sub_reduce_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_unit: exact add/sub/compare/reduce of two fractions
// Front queues classified requests, back runs the Euclid reductions.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   mode, num_a, den_a, num_b, den_b
// out_ch   out  valid/ready   res_num, res_den, equal, error
//
// Divides: all run on the shared 64-bit restoring divider; each Euclid
//   step is one divide, plus two divides per reduction (one reduction for
//   reduce, two for compare, three for add/sub).
// Reset: rst_n synchronous, active low; clears queue and sequencer state.
// Stalls: the front queue (two requests) takes requests while the back works
//   until full; a held result keeps the back from starting the next request.
// ----------------------------------------------------------------------------
module rational_add_sub_reduce_unit #(
  parameter int OPERAND_BITS = rasr_pkg::OPERAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rasr_in_if.sink     in_ch,
  rasr_out_if.source  out_ch
);
  import rasr_pkg::*;

  logic                  job_valid, job_ready, job_err, job_neg_a, job_neg_b;
  logic [1:0]            job_mode;
  logic [OPERAND_BITS:0] job_mag_a, job_den_a, job_mag_b, job_den_b;

  // front: zero-denominator check, sign/magnitude split, queue
  rasr_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
    .clk, .rst_n, .in_ch,
    .job_valid, .job_ready, .job_mode, .job_err,
    .job_neg_a, .job_mag_a, .job_den_a,
    .job_neg_b, .job_mag_b, .job_den_b
  );

  // back: up to three reductions on one divider, cross-multiply, result register
  rasr_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
    .clk, .rst_n,
    .job_valid, .job_ready, .job_mode, .job_err,
    .job_neg_a, .job_mag_a, .job_den_a,
    .job_neg_b, .job_mag_b, .job_den_b,
    .out_ch
  );

endmodule
